// File: hdl/rci_pkg.sv
// Shared widths, stage records and helpers for the ray / cylinder intersect pipeline.
// No dependencies; every other file in hdl imports this package.
package rci_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int COORD_WIDTH = 32;

    localparam int FIELD_W = 32;
    localparam int CW_EFF  = (COORD_WIDTH > FIELD_W) ? FIELD_W : COORD_WIDTH;
    localparam int RAD_W   = 31;
    localparam int DIST_W  = 31;
    localparam int CNT_W   = 2;
    localparam int IDX_W   = 2;
    localparam int HALF_W  = 32;

    localparam int DIFF_W = FIELD_W + 1;        // origin minus centre
    localparam int SQ_W   = 2 * FIELD_W;        // dx*dx
    localparam int PROD_W = FIELD_W + DIFF_W;   // dx*X
    localparam int H_W    = PROD_W + 1;         // h and cross term
    localparam int A_W    = 64;                 // dx^2 + dy^2, at most 2^63
    localparam int R2_W   = 2 * RAD_W;
    localparam int C_W    = 63;                 // cross term magnitude when real
    localparam int D_W    = 126;                // discriminant
    localparam int S_W    = D_W / 2;            // square root
    localparam int N_W    = H_W + 1;            // signed root numerator
    localparam int NM_W   = N_W - 1;
    localparam int EPS_W  = NM_W + 14;          // numerator times 10000
    localparam int Q_W    = DIST_W;
    localparam int DIV_W  = A_W + Q_W;          // divider remainder

    localparam logic [DIST_W-1:0] DIST_MAX     = '1;
    localparam logic [RAD_W-1:0]  RADIUS_RESET = RAD_W'(65536);

    localparam logic [IDX_W-1:0] REG_CENTRE_X = 2'd0;
    localparam logic [IDX_W-1:0] REG_CENTRE_Y = 2'd1;
    localparam logic [IDX_W-1:0] REG_RADIUS   = 2'd2;

    typedef struct packed {
        logic                  valid;
        logic                  degen;
        logic                  real_ok;
        logic signed [H_W-1:0] h;
        logic [A_W-1:0]        a;
        logic [D_W-1:0]        d;
    } front_t;

    typedef struct packed {
        logic                  valid;
        logic                  degen;
        logic                  real_ok;
        logic signed [H_W-1:0] h;
        logic [A_W-1:0]        a;
        logic [S_W-1:0]        s;
    } root_in_t;

    typedef struct packed {
        logic               valid;
        logic               degen;
        logic [CNT_W-1:0]   count;
        logic               sat1;
        logic               sat2;
        logic [A_W-1:0]     a;
        logic [DIV_W-1:0]   num1;
        logic [DIV_W-1:0]   num2;
    } div_in_t;

    typedef struct packed {
        logic [CNT_W-1:0]  hit_count;
        logic [DIST_W-1:0] first_distance;
        logic [DIST_W-1:0] second_distance;
        logic              degenerate;
    } res_t;

    function automatic logic signed [FIELD_W-1:0] sext_coord(input logic [FIELD_W-1:0] v);
        logic signed [FIELD_W-1:0] t;
        t = v << (FIELD_W - CW_EFF);
        return t >>> (FIELD_W - CW_EFF);
    endfunction

endpackage

// File: hdl/rci_front.sv
// Front end: offsets, products, A, h, cross term and discriminant, seven stages.
// Depends on rci_pkg.
module rci_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic signed [rci_pkg::FIELD_W-1:0]   origin_x,
    input  logic signed [rci_pkg::FIELD_W-1:0]   origin_y,
    input  logic signed [rci_pkg::FIELD_W-1:0]   dir_x,
    input  logic signed [rci_pkg::FIELD_W-1:0]   dir_y,
    input  logic signed [rci_pkg::FIELD_W-1:0]   centre_x,
    input  logic signed [rci_pkg::FIELD_W-1:0]   centre_y,
    input  logic [rci_pkg::RAD_W-1:0]            radius,
    output rci_pkg::front_t                      front
);
    import rci_pkg::*;

    localparam int STAGES = 7;
    localparam int PP_W   = 2 * HALF_W;
    localparam int CH_W   = C_W - HALF_W;
    localparam int AH_W   = A_W - HALF_W;
    localparam int RH_W   = R2_W - HALF_W;

    logic [STAGES-1:0] vld_reg;

    // stage 1
    logic                       s1_degen_reg;
    logic signed [FIELD_W-1:0]  s1_dx_reg, s1_dy_reg;
    logic signed [DIFF_W-1:0]   s1_x_reg, s1_y_reg;
    logic [RAD_W-1:0]           s1_r_reg;
    // stage 2
    logic                       s2_degen_reg;
    logic signed [SQ_W-1:0]     s2_xx_reg, s2_yy_reg;
    logic signed [PROD_W-1:0]   s2_dxx_reg, s2_dyy_reg, s2_dxy_reg, s2_dyx_reg;
    logic [R2_W-1:0]            s2_r2_reg;
    // stage 3
    logic                       s3_degen_reg;
    logic [A_W-1:0]             s3_a_reg;
    logic signed [H_W-1:0]      s3_h_reg, s3_cr_reg;
    logic [R2_W-1:0]            s3_r2_reg;
    // stage 4
    logic                       s4_degen_reg, s4_real_reg;
    logic [A_W-1:0]             s4_a_reg;
    logic signed [H_W-1:0]      s4_h_reg;
    logic [C_W-1:0]             s4_c_reg;
    logic [R2_W-1:0]            s4_r2_reg;
    // stage 5
    logic                       s5_degen_reg, s5_real_reg;
    logic [A_W-1:0]             s5_a_reg;
    logic signed [H_W-1:0]      s5_h_reg;
    logic [PP_W-1:0]            s5_cll_reg;
    logic [HALF_W+CH_W-1:0]     s5_clh_reg;
    logic [2*CH_W-1:0]          s5_chh_reg;
    logic [PP_W-1:0]            s5_all_reg;
    logic [HALF_W+RH_W-1:0]     s5_alh_reg;
    logic [AH_W+HALF_W-1:0]     s5_ahl_reg;
    logic [AH_W+RH_W-1:0]       s5_ahh_reg;
    // stage 6
    logic                       s6_degen_reg, s6_real_reg;
    logic [A_W-1:0]             s6_a_reg;
    logic signed [H_W-1:0]      s6_h_reg;
    logic [D_W-1:0]             s6_c2_reg, s6_ar2_reg;
    // stage 7
    logic                       s7_degen_reg, s7_real_reg;
    logic [A_W-1:0]             s7_a_reg;
    logic signed [H_W-1:0]      s7_h_reg;
    logic [D_W-1:0]             s7_d_reg;

    logic signed [FIELD_W-1:0]  ox, oy, dxs, dys, cxs, cys;
    logic signed [DIFF_W-1:0]   x_next, y_next;
    logic [H_W-1:0]             crm;
    logic [D_W:0]               diff;

    always_comb
    begin
        ox     = sext_coord(origin_x);
        oy     = sext_coord(origin_y);
        dxs    = sext_coord(dir_x);
        dys    = sext_coord(dir_y);
        cxs    = sext_coord(centre_x);
        cys    = sext_coord(centre_y);
        x_next = DIFF_W'(ox) - DIFF_W'(cxs);
        y_next = DIFF_W'(oy) - DIFF_W'(cys);
        crm    = s3_cr_reg[H_W-1] ? $unsigned(-s3_cr_reg) : $unsigned(s3_cr_reg);
        diff   = {1'b0, s6_ar2_reg} - {1'b0, s6_c2_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_degen_reg <= (dxs == '0) && (dys == '0);
            s1_dx_reg    <= dxs;
            s1_dy_reg    <= dys;
            s1_x_reg     <= x_next;
            s1_y_reg     <= y_next;
            s1_r_reg     <= radius;

            s2_degen_reg <= s1_degen_reg;
            s2_xx_reg    <= SQ_W'(s1_dx_reg) * SQ_W'(s1_dx_reg);
            s2_yy_reg    <= SQ_W'(s1_dy_reg) * SQ_W'(s1_dy_reg);
            s2_dxx_reg   <= PROD_W'(s1_dx_reg) * PROD_W'(s1_x_reg);
            s2_dyy_reg   <= PROD_W'(s1_dy_reg) * PROD_W'(s1_y_reg);
            s2_dxy_reg   <= PROD_W'(s1_dx_reg) * PROD_W'(s1_y_reg);
            s2_dyx_reg   <= PROD_W'(s1_dy_reg) * PROD_W'(s1_x_reg);
            s2_r2_reg    <= R2_W'(s1_r_reg) * R2_W'(s1_r_reg);

            s3_degen_reg <= s2_degen_reg;
            s3_a_reg     <= $unsigned(s2_xx_reg) + $unsigned(s2_yy_reg);
            s3_h_reg     <= H_W'(s2_dxx_reg) + H_W'(s2_dyy_reg);
            s3_cr_reg    <= H_W'(s2_dxy_reg) - H_W'(s2_dyx_reg);
            s3_r2_reg    <= s2_r2_reg;

            // cross term must stay below 2^63 for a real pair of roots
            s4_degen_reg <= s3_degen_reg;
            s4_real_reg  <= (crm[H_W-1:C_W] == '0);
            s4_a_reg     <= s3_a_reg;
            s4_h_reg     <= s3_h_reg;
            s4_c_reg     <= crm[C_W-1:0];
            s4_r2_reg    <= s3_r2_reg;

            s5_degen_reg <= s4_degen_reg;
            s5_real_reg  <= s4_real_reg;
            s5_a_reg     <= s4_a_reg;
            s5_h_reg     <= s4_h_reg;
            s5_cll_reg   <= PP_W'(s4_c_reg[HALF_W-1:0]) * PP_W'(s4_c_reg[HALF_W-1:0]);
            s5_clh_reg   <= (HALF_W+CH_W)'(s4_c_reg[HALF_W-1:0])
                            * (HALF_W+CH_W)'(s4_c_reg[C_W-1:HALF_W]);
            s5_chh_reg   <= (2*CH_W)'(s4_c_reg[C_W-1:HALF_W])
                            * (2*CH_W)'(s4_c_reg[C_W-1:HALF_W]);
            s5_all_reg   <= PP_W'(s4_a_reg[HALF_W-1:0]) * PP_W'(s4_r2_reg[HALF_W-1:0]);
            s5_alh_reg   <= (HALF_W+RH_W)'(s4_a_reg[HALF_W-1:0])
                            * (HALF_W+RH_W)'(s4_r2_reg[R2_W-1:HALF_W]);
            s5_ahl_reg   <= (AH_W+HALF_W)'(s4_a_reg[A_W-1:HALF_W])
                            * (AH_W+HALF_W)'(s4_r2_reg[HALF_W-1:0]);
            s5_ahh_reg   <= (AH_W+RH_W)'(s4_a_reg[A_W-1:HALF_W])
                            * (AH_W+RH_W)'(s4_r2_reg[R2_W-1:HALF_W]);

            // cross partial counted twice: shift by one more
            s6_degen_reg <= s5_degen_reg;
            s6_real_reg  <= s5_real_reg;
            s6_a_reg     <= s5_a_reg;
            s6_h_reg     <= s5_h_reg;
            s6_c2_reg    <= D_W'(s5_cll_reg) + (D_W'(s5_clh_reg) << (HALF_W + 1))
                            + (D_W'(s5_chh_reg) << (2 * HALF_W));
            s6_ar2_reg   <= D_W'(s5_all_reg) + (D_W'(s5_alh_reg) << HALF_W)
                            + (D_W'(s5_ahl_reg) << HALF_W) + (D_W'(s5_ahh_reg) << (2 * HALF_W));

            s7_degen_reg <= s6_degen_reg;
            s7_real_reg  <= s6_real_reg && !diff[D_W];
            s7_a_reg     <= s6_a_reg;
            s7_h_reg     <= s6_h_reg;
            s7_d_reg     <= diff[D_W-1:0];
        end
    end

    assign front.valid   = vld_reg[STAGES-1];
    assign front.degen   = s7_degen_reg;
    assign front.real_ok = s7_real_reg;
    assign front.h       = s7_h_reg;
    assign front.a       = s7_a_reg;
    assign front.d       = s7_d_reg;

endmodule

// File: hdl/rci_sqrt.sv
// Integer square root of the discriminant, one result bit per pipeline stage.
// Depends on rci_pkg.
module rci_sqrt (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  rci_pkg::front_t    front,
    output rci_pkg::root_in_t  root
);
    import rci_pkg::*;

    typedef struct packed {
        logic                  degen;
        logic                  real_ok;
        logic signed [H_W-1:0] h;
        logic [A_W-1:0]        a;
        logic [D_W-1:0]        rem;
        logic [D_W-1:0]        res;
    } sq_t;

    logic [S_W-1:0] vld_reg;
    sq_t            st_reg  [S_W];
    sq_t            st_next [S_W];
    sq_t            src     [S_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[S_W-2:0], front.valid};
    end

    for (genvar k = 0; k < S_W; k++)
    begin : g_step
        // bit weight 4^(S_W-1-k)
        localparam logic [D_W-1:0] BIT_K = D_W'(1) << (2 * (S_W - 1 - k));
        logic [D_W-1:0] trial;

        if (k == 0)
        begin : g_head
            assign src[k] = '{degen: front.degen, real_ok: front.real_ok, h: front.h,
                              a: front.a, rem: front.d, res: '0};
        end
        else
        begin : g_link
            assign src[k] = st_reg[k-1];
        end

        always_comb
        begin
            trial      = src[k].res + BIT_K;
            st_next[k] = src[k];
            if (src[k].rem >= trial)
            begin
                st_next[k].rem = src[k].rem - trial;
                st_next[k].res = (src[k].res >> 1) + BIT_K;
            end
            else
            begin
                st_next[k].res = src[k].res >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
                st_reg[k] <= st_next[k];
        end
    end

    assign root.valid   = vld_reg[S_W-1];
    assign root.degen   = st_reg[S_W-1].degen;
    assign root.real_ok = st_reg[S_W-1].real_ok;
    assign root.h       = st_reg[S_W-1].h;
    assign root.a       = st_reg[S_W-1].a;
    assign root.s       = st_reg[S_W-1].res[S_W-1:0];

endmodule

// File: hdl/rci_root.sv
// Root numerators, forward test against epsilon, saturation check and hit count.
// Three stages. Depends on rci_pkg.
module rci_root (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  rci_pkg::root_in_t  root,
    output rci_pkg::div_in_t   div_in
);
    import rci_pkg::*;

    localparam int STAGES = 3;

    // n * 10000, with 10000 = 2^13 + 2^10 + 2^9 + 2^8 + 2^4
    function automatic logic [EPS_W-1:0] eps_scale(input logic [NM_W-1:0] n);
        logic [EPS_W-1:0] w;
        w = EPS_W'(n);
        return (w << 13) + (w << 10) + (w << 9) + (w << 8) + (w << 4);
    endfunction

    logic [STAGES-1:0] vld_reg;

    logic                  r1_degen_reg, r1_real_reg, r1_dzero_reg;
    logic [A_W-1:0]        r1_a_reg;
    logic signed [N_W-1:0] r1_n1_reg, r1_n2_reg;

    logic                  r2_degen_reg, r2_real_reg, r2_dzero_reg;
    logic [A_W-1:0]        r2_a_reg;
    logic                  r2_pos1_reg, r2_pos2_reg;
    logic [EPS_W-1:0]      r2_prod1_reg, r2_prod2_reg;
    logic [DIV_W-1:0]      r2_num1_reg, r2_num2_reg;

    logic                  r3_degen_reg, r3_sat1_reg, r3_sat2_reg;
    logic [CNT_W-1:0]      r3_count_reg;
    logic [A_W-1:0]        r3_a_reg;
    logic [DIV_W-1:0]      r3_num1_reg, r3_num2_reg;

    logic signed [N_W-1:0] hx, sv;
    logic                  fwd1, fwd2, sat1, sat2;
    logic [DIV_W-1:0]      a_top;
    logic [CNT_W-1:0]      count;

    always_comb
    begin
        hx    = N_W'(root.h);
        sv    = $signed(N_W'(root.s));
        fwd1  = r2_pos1_reg && (r2_prod1_reg > EPS_W'(r2_a_reg));
        fwd2  = r2_pos2_reg && (r2_prod2_reg > EPS_W'(r2_a_reg));
        a_top = DIV_W'(r2_a_reg) << Q_W;
        sat1  = r2_num1_reg >= a_top;
        sat2  = r2_num2_reg >= a_top;
        // a zero discriminant gives one double root, counted once
        priority if (r2_degen_reg || !r2_real_reg)
            count = CNT_W'(0);
        else if (r2_dzero_reg)
            count = fwd1 ? CNT_W'(1) : CNT_W'(0);
        else if (fwd1 && fwd2)
            count = CNT_W'(2);
        else if (fwd1 || fwd2)
            count = CNT_W'(1);
        else
            count = CNT_W'(0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[STAGES-2:0], root.valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_degen_reg <= root.degen;
            r1_real_reg  <= root.real_ok;
            r1_dzero_reg <= (root.s == '0);
            r1_a_reg     <= root.a;
            r1_n1_reg    <= sv - hx;
            r1_n2_reg    <= -(hx + sv);

            r2_degen_reg <= r1_degen_reg;
            r2_real_reg  <= r1_real_reg;
            r2_dzero_reg <= r1_dzero_reg;
            r2_a_reg     <= r1_a_reg;
            r2_pos1_reg  <= !r1_n1_reg[N_W-1];
            r2_pos2_reg  <= !r1_n2_reg[N_W-1];
            r2_prod1_reg <= eps_scale(r1_n1_reg[NM_W-1:0]);
            r2_prod2_reg <= eps_scale(r1_n2_reg[NM_W-1:0]);
            r2_num1_reg  <= DIV_W'(r1_n1_reg[NM_W-1:0]) << FRAC_BITS;
            r2_num2_reg  <= DIV_W'(r1_n2_reg[NM_W-1:0]) << FRAC_BITS;

            // larger root first; a lone near root moves into first place
            r3_degen_reg <= r2_degen_reg;
            r3_count_reg <= count;
            r3_a_reg     <= r2_a_reg;
            r3_num1_reg  <= fwd1 ? r2_num1_reg : r2_num2_reg;
            r3_sat1_reg  <= fwd1 ? sat1 : sat2;
            r3_num2_reg  <= r2_num2_reg;
            r3_sat2_reg  <= sat2;
        end
    end

    assign div_in.valid = vld_reg[STAGES-1];
    assign div_in.degen = r3_degen_reg;
    assign div_in.count = r3_count_reg;
    assign div_in.sat1  = r3_sat1_reg;
    assign div_in.sat2  = r3_sat2_reg;
    assign div_in.a     = r3_a_reg;
    assign div_in.num1  = r3_num1_reg;
    assign div_in.num2  = r3_num2_reg;

endmodule

// File: hdl/rci_div.sv
// Two restoring dividers side by side, one quotient bit per stage, plus result forming.
// Depends on rci_pkg.
module rci_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  rci_pkg::div_in_t  div_in,
    output logic              res_valid,
    output rci_pkg::res_t     res
);
    import rci_pkg::*;

    typedef struct packed {
        logic             degen;
        logic [CNT_W-1:0] count;
        logic             sat1;
        logic             sat2;
        logic [A_W-1:0]   a;
        logic [DIV_W-1:0] rem1;
        logic [DIV_W-1:0] rem2;
        logic [Q_W-1:0]   q1;
        logic [Q_W-1:0]   q2;
    } dv_t;

    logic [Q_W-1:0] vld_reg;
    dv_t            st_reg  [Q_W];
    dv_t            st_next [Q_W];
    dv_t            src     [Q_W];
    dv_t            last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[Q_W-2:0], div_in.valid};
    end

    for (genvar k = 0; k < Q_W; k++)
    begin : g_step
        localparam int B = Q_W - 1 - k;
        logic [DIV_W-1:0] sub;

        if (k == 0)
        begin : g_head
            assign src[k] = '{degen: div_in.degen, count: div_in.count, sat1: div_in.sat1,
                              sat2: div_in.sat2, a: div_in.a, rem1: div_in.num1,
                              rem2: div_in.num2, q1: '0, q2: '0};
        end
        else
        begin : g_link
            assign src[k] = st_reg[k-1];
        end

        always_comb
        begin
            sub        = DIV_W'(src[k].a) << B;
            st_next[k] = src[k];
            if (src[k].rem1 >= sub)
            begin
                st_next[k].rem1  = src[k].rem1 - sub;
                st_next[k].q1[B] = 1'b1;
            end
            if (src[k].rem2 >= sub)
            begin
                st_next[k].rem2  = src[k].rem2 - sub;
                st_next[k].q2[B] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
                st_reg[k] <= st_next[k];
        end
    end

    assign last      = st_reg[Q_W-1];
    assign res_valid = vld_reg[Q_W-1];

    always_comb
    begin
        res.hit_count       = last.count;
        res.degenerate      = last.degen;
        res.first_distance  = '0;
        res.second_distance = '0;
        if (last.count != CNT_W'(0))
            res.first_distance = last.sat1 ? DIST_MAX : last.q1;
        if (last.count == CNT_W'(2))
            res.second_distance = last.sat2 ? DIST_MAX : last.q2;
    end

endmodule

// File: hdl/rci_outq.sv
// Two-entry output queue; its fill level gates the whole pipeline.
// Depends on rci_pkg.
module rci_outq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           res_valid,
    input  rci_pkg::res_t  res_in,
    input  logic           out_stall,
    output logic           en,
    output logic           out_valid,
    output rci_pkg::res_t  res_out
);
    import rci_pkg::*;

    localparam int QDEPTH = 2;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    res_t              slot_reg [QDEPTH];
    logic              push, pop;

    // full queue freezes every stage; one free slot absorbs the item in flight
    assign en        = (cnt_reg != QCNT_W'(QDEPTH));
    assign out_valid = (cnt_reg != '0);
    assign res_out   = slot_reg[rd_ptr_reg];
    assign push      = en && res_valid;
    assign pop       = out_valid && !out_stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        unique case ({push, pop})
            2'b10:   cnt_next = cnt_reg + QCNT_W'(1);
            2'b01:   cnt_next = cnt_reg - QCNT_W'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= res_in;
    end

endmodule

// File: hdl/ray_cylinder_intersect_top.sv
// Ray against vertical cylinder in the plane across its axis, Q16.16.
// From input accept to out_valid an item passes the front end, square root,
// root select and divider stages and then the output queue. Throughput one
// item per cycle; the pipeline moves while the 2-entry output queue has room.
// Reset (rst_n low, async) empties the pipeline; centre 0, radius 1.0.
// Depends on rci_pkg, rci_front, rci_sqrt, rci_root, rci_div, rci_outq.
module ray_cylinder_intersect_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [rci_pkg::IDX_W-1:0]            cfg_index,
    input  logic [rci_pkg::FIELD_W-1:0]          cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [rci_pkg::FIELD_W-1:0]   origin_x,
    input  logic signed [rci_pkg::FIELD_W-1:0]   origin_y,
    input  logic signed [rci_pkg::FIELD_W-1:0]   dir_x,
    input  logic signed [rci_pkg::FIELD_W-1:0]   dir_y,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [rci_pkg::CNT_W-1:0]            hit_count,
    output logic [rci_pkg::DIST_W-1:0]           first_distance,
    output logic [rci_pkg::DIST_W-1:0]           second_distance,
    output logic                                 degenerate
);
    import rci_pkg::*;

    logic signed [FIELD_W-1:0] centre_x_reg, centre_y_reg;
    logic [RAD_W-1:0]          radius_reg;
    logic                      en;
    front_t                    front;
    root_in_t                  root;
    div_in_t                   div_in;
    logic                      res_valid;
    res_t                      res, res_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centre_x_reg <= '0;
            centre_y_reg <= '0;
            radius_reg   <= RADIUS_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_CENTRE_X: centre_x_reg <= cfg_data;
                REG_CENTRE_Y: centre_y_reg <= cfg_data;
                REG_RADIUS:   radius_reg   <= cfg_data[RAD_W-1:0];
                default:      ;
            endcase
        end
    end

    assign in_stall = !en;

    rci_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .origin_x (origin_x),
        .origin_y (origin_y),
        .dir_x    (dir_x),
        .dir_y    (dir_y),
        .centre_x (centre_x_reg),
        .centre_y (centre_y_reg),
        .radius   (radius_reg),
        .front    (front)
    );

    rci_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .front (front),
        .root  (root)
    );

    rci_root u_root (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .root   (root),
        .div_in (div_in)
    );

    rci_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .div_in    (div_in),
        .res_valid (res_valid),
        .res       (res)
    );

    rci_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_in    (res),
        .out_stall (out_stall),
        .en        (en),
        .out_valid (out_valid),
        .res_out   (res_out)
    );

    assign hit_count       = res_out.hit_count;
    assign first_distance  = res_out.first_distance;
    assign second_distance = res_out.second_distance;
    assign degenerate      = res_out.degenerate;

    a_degen_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> hit_count == '0)
        else $error("degenerate ray reported hits");

    a_no_hit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit_count == '0 |-> first_distance == '0 && second_distance == '0)
        else $error("distance set with no hit");

    a_second_only_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit_count != CNT_W'(2) |-> second_distance == '0)
        else $error("second distance set without two hits");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit_count == CNT_W'(2) |-> first_distance >= second_distance)
        else $error("pair of hits out of order");

endmodule
